FILE: rtl/hmf_pkg.sv
package hmf_pkg;

    // parse phase codes, also the parse_state output
    localparam logic [3:0] PH_HEADER    = 4'd0;
    localparam logic [3:0] PH_SIZE      = 4'd1;
    localparam logic [3:0] PH_DATA      = 4'd2;
    localparam logic [3:0] PH_EXT       = 4'd3;
    localparam logic [3:0] PH_TRAILER   = 4'd4;
    localparam logic [3:0] PH_LENGTH    = 4'd5;
    localparam logic [3:0] PH_WEBSOCKET = 4'd6;
    localparam logic [3:0] PH_DONE      = 4'd7;
    localparam logic [3:0] PH_ERROR     = 4'd8;

    // header name indexes
    localparam logic [1:0] KEY_CL = 2'd0;
    localparam logic [1:0] KEY_TE = 2'd1;
    localparam logic [1:0] KEY_WK = 2'd2;
    localparam logic [1:0] KEY_WA = 2'd3;

    localparam logic [5:0] MAX_LINES = 6'd32;
    localparam logic [8:0] VALUE_MAX = 9'd256;
    localparam logic [8:0] TOKEN_MAX = 9'd256;
    localparam logic [8:0] COL_MAX   = 9'd511;
    localparam logic [5:0] LIMIT_RESET = 6'd32;
    localparam logic [31:0] HEX_ACC_MAX = 32'h07FF_FFFF;
    localparam logic [31:0] LEN_MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0] DEC_LIMIT_LO = LEN_MAX32 / 32'd10;
    localparam logic [31:0] DEC_LIMIT_HI = (LEN_MAX32 - 32'd9) / 32'd10;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // lower-case header names, right aligned
    localparam logic [159:0] KEY_CL_TEXT = "content-length";
    localparam logic [159:0] KEY_TE_TEXT = "transfer-encoding";
    localparam logic [159:0] KEY_WK_TEXT = "sec-websocket-key";
    localparam logic [159:0] KEY_WA_TEXT = "sec-websocket-accept";
    localparam logic [55:0]  CHUNKED_TEXT = "chunked";

    // one classified byte
    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic [7:0] lower;
        logic       is_digit;
        logic       is_hex;
        logic [3:0] nib;
        logic       is_space;
    } item_t;

    // head of the queue toward the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    function automatic item_t classify(input logic op, input logic [7:0] b);
        item_t r;
        r.op = op;
        r.b = b;
        r.lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        r.is_digit = (b >= "0" && b <= "9");
        r.is_space = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
        r.is_hex = 1'b1;
        if (b >= "0" && b <= "9")
            r.nib = 4'(b - "0");
        else if (b >= "a" && b <= "f")
            r.nib = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F")
            r.nib = 4'(b - "A" + 8'd10);
        else
        begin
            r.nib = 4'd0;
            r.is_hex = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [4:0] key_len(input logic [1:0] k);
        logic [4:0] r;
        unique case (k)
            KEY_CL:  r = 5'd14;
            KEY_TE:  r = 5'd17;
            KEY_WK:  r = 5'd17;
            default: r = 5'd20;
        endcase
        return r;
    endfunction

    // character i of header name k, valid for i below its length
    function automatic logic [7:0] key_char(input logic [1:0] k, input logic [4:0] i);
        logic [159:0] s;
        logic [159:0] t;
        logic [4:0]   pos;
        unique case (k)
            KEY_CL:  s = KEY_CL_TEXT;
            KEY_TE:  s = KEY_TE_TEXT;
            KEY_WK:  s = KEY_WK_TEXT;
            default: s = KEY_WA_TEXT;
        endcase
        pos = key_len(k) - 5'd1 - i;
        t = s >> {pos, 3'b000};
        return t[7:0];
    endfunction

    function automatic logic [7:0] chunked_char(input logic [2:0] i);
        logic [55:0] t;
        logic [2:0]  pos;
        pos = 3'd6 - i;
        t = CHUNKED_TEXT >> {pos, 3'b000};
        return t[7:0];
    endfunction

    // largest accumulator that may take decimal digit d without overflow
    function automatic logic [31:0] dec_limit(input logic [3:0] d);
        return (d > 4'd7) ? DEC_LIMIT_HI : DEC_LIMIT_LO;
    endfunction

endpackage

FILE: rtl/hmf_front.sv
module hmf_front (
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                operation,
    input  logic [7:0]          data_byte,
    input  logic                queue_full,
    output logic                push,
    output hmf_pkg::item_t      push_item
);

    // accept while the queue has room
    assign item_stall = queue_full;
    assign push = item_valid && !queue_full;

    // classify the byte once for the back end
    assign push_item = hmf_pkg::classify(operation, data_byte);

endmodule

FILE: rtl/hmf_queue.sv
module hmf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hmf_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output hmf_pkg::head_t head
);

    hmf_pkg::item_t ent_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;

    assign full = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.item = ent_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/hmf_back.sv
module hmf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  hmf_pkg::head_t head,
    output logic           pop,
    input  logic [5:0]     line_limit,
    output logic           result_valid,
    input  logic           result_stall,
    output logic [3:0]     parse_state,
    output logic           payload_byte,
    output logic [9:0]     status_code,
    output logic [1:0]     http_version,
    output logic [30:0]    body_length
);

    // value parse modes
    localparam logic [2:0] VM_SKIP    = 3'd0;
    localparam logic [2:0] VM_LEADING = 3'd1;
    localparam logic [2:0] VM_SIGNED  = 3'd2;
    localparam logic [2:0] VM_DIGITS  = 3'd3;
    localparam logic [2:0] VM_BAD     = 3'd4;

    // status line modes
    localparam logic [2:0] SM_VERSION = 3'd0;
    localparam logic [2:0] SM_SPACES  = 3'd1;
    localparam logic [2:0] SM_TOKEN   = 3'd2;
    localparam logic [2:0] SM_DONE    = 3'd3;
    localparam logic [2:0] SM_BAD     = 3'd4;

    typedef struct packed {
        logic [3:0]  phase;
        logic [8:0]  col;
        logic [5:0]  lcnt;
        logic [4:0]  nm;
        logic [3:0]  found;
        logic [3:0]  verdict;
        logic [31:0] acc;
        logic [9:0]  status;
        logic [1:0]  version;
        logic [30:0] declared;
        logic [30:0] remaining;
        logic [8:0]  span;
        logic [2:0]  vmode;
        logic        neg;
        logic        mism;
        logic [2:0]  smode;
        logic        crp;
    } st_t;

    localparam st_t ST_RESET = '{phase: hmf_pkg::PH_HEADER, nm: 5'b01111, default: '0};

    st_t  st_reg, st_next;
    logic payload_reg, payload_next;
    logic valid_reg;

    function automatic st_t clear_line(st_t s);
        st_t r;
        r = s;
        r.col = '0;
        r.nm = {1'b0, ~s.found};
        r.acc = '0;
        r.span = '0;
        r.vmode = VM_SKIP;
        r.neg = 1'b0;
        r.mism = 1'b0;
        r.smode = SM_VERSION;
        r.crp = 1'b0;
        return r;
    endfunction

    function automatic st_t clear_all(st_t s);
        st_t r;
        r = s;
        r.phase = hmf_pkg::PH_HEADER;
        r.lcnt = '0;
        r.found = '0;
        r.verdict = '0;
        r.status = '0;
        r.version = '0;
        r.declared = '0;
        r.remaining = '0;
        return clear_line(r);
    endfunction

    function automatic logic [1:0] active_key(logic [4:0] nm);
        logic [1:0] k;
        k = hmf_pkg::KEY_CL;
        for (int i = 3; i >= 0; i--)
            if (nm[i])
                k = 2'(i);
        return k;
    endfunction

    // version and code on the first line
    function automatic st_t status_byte(st_t s, hmf_pkg::item_t it, logic [8:0] c);
        st_t r;
        logic [7:0] b;
        r = s;
        b = it.b;
        if (r.smode == SM_VERSION)
        begin
            if (c == 9'd5 && b != "1")
                r.smode = SM_BAD;
            else if (c == 9'd6 && b != ".")
                r.smode = SM_BAD;
            else if (c == 9'd7)
            begin
                if (b == "1")
                    r.version = 2'd2;
                else if (b == "0")
                    r.version = 2'd1;
                else
                    r.smode = SM_BAD;
            end
            else if (c == 9'd8)
                r.smode = SM_SPACES;
        end
        else
        begin
            if (r.smode == SM_SPACES && b != hmf_pkg::CH_SPACE)
                r.smode = SM_TOKEN;
            if (r.smode == SM_TOKEN)
            begin
                if (b == hmf_pkg::CH_SPACE)
                    r.smode = SM_DONE;
                else
                begin
                    r.span = r.span + 9'd1;
                    if (r.span >= hmf_pkg::TOKEN_MAX)
                        r.smode = SM_BAD;
                    else if (r.span == 9'd1 && b == "-")
                        r.neg = 1'b1;
                    else if (it.is_digit)
                    begin
                        r.acc = r.acc * 32'd10 + 32'(it.nib);
                        if (r.acc > 32'd999)
                            r.smode = SM_BAD;
                    end
                    else
                        r.smode = SM_BAD;
                end
            end
        end
        return r;
    endfunction

    // header value after a matched name
    function automatic st_t value_byte(st_t s, hmf_pkg::item_t it, logic [1:0] k);
        st_t r;
        logic skip;
        r = s;
        skip = 1'b0;
        if (r.vmode == VM_SKIP)
        begin
            if (it.b == hmf_pkg::CH_SPACE || it.b == ":")
                skip = 1'b1;
            else
                r.vmode = VM_LEADING;
        end
        if (!skip)
        begin
            if (r.span < hmf_pkg::VALUE_MAX)
                r.span = r.span + 9'd1;
            if (k == hmf_pkg::KEY_TE && r.span <= 9'd7
                && it.b != hmf_pkg::chunked_char(3'(r.span - 9'd1)))
                r.mism = 1'b1;
            if (k == hmf_pkg::KEY_CL && r.vmode != VM_BAD)
            begin
                if (r.vmode == VM_LEADING && !it.is_digit)
                begin
                    if (!it.is_space)
                    begin
                        if (it.b == "+" || it.b == "-")
                        begin
                            r.neg = (it.b == "-");
                            r.vmode = VM_SIGNED;
                        end
                        else
                            r.vmode = VM_BAD;
                    end
                end
                else if (!it.is_digit)
                    r.vmode = VM_BAD;
                else
                begin
                    r.vmode = VM_DIGITS;
                    if (r.acc > hmf_pkg::dec_limit(it.nib))
                        r.vmode = VM_BAD;
                    else
                        r.acc = r.acc * 32'd10 + 32'(it.nib);
                end
            end
        end
        return r;
    endfunction

    // one content byte of a header line
    function automatic st_t header_content(st_t s, hmf_pkg::item_t it);
        st_t r;
        logic [8:0] c;
        logic [8:0] len;
        r = s;
        c = s.col;
        if (s.lcnt == 6'd0)
            r = status_byte(r, it, c);
        if (r.nm[4])
            r = value_byte(r, it, active_key(r.nm));
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                len = {4'd0, hmf_pkg::key_len(2'(k))};
                if (r.nm[k] && c < len
                    && it.lower != hmf_pkg::key_char(2'(k), c[4:0]))
                    r.nm[k] = 1'b0;
            end
            for (int k = 0; k < 4; k++)
            begin
                len = {4'd0, hmf_pkg::key_len(2'(k))};
                if (r.nm[k] && c + 9'd1 == len)
                    r.nm[4] = 1'b1;
            end
        end
        if (r.col < hmf_pkg::COL_MAX)
            r.col = r.col + 9'd1;
        return r;
    endfunction

    function automatic st_t count_line(st_t s, logic [5:0] limit);
        st_t r;
        logic [5:0] lim;
        r = s;
        lim = (limit < hmf_pkg::MAX_LINES) ? limit : hmf_pkg::MAX_LINES;
        if (r.lcnt < lim)
            r.lcnt = r.lcnt + 6'd1;
        else
            r.phase = hmf_pkg::PH_ERROR;
        return r;
    endfunction

    // framing choice at the empty line
    function automatic st_t decide(st_t s);
        st_t r;
        r = s;
        if (r.verdict[hmf_pkg::KEY_CL])
        begin
            r.remaining = r.declared;
            r.phase = (r.declared == 31'd0) ? hmf_pkg::PH_DONE : hmf_pkg::PH_LENGTH;
        end
        else if (r.verdict[hmf_pkg::KEY_TE])
        begin
            r.declared = '0;
            r.phase = hmf_pkg::PH_SIZE;
            r = clear_line(r);
        end
        else if (r.verdict[3:2] != 2'd0)
            r.phase = hmf_pkg::PH_WEBSOCKET;
        else
            r.phase = (r.status == 10'd200) ? hmf_pkg::PH_ERROR : hmf_pkg::PH_DONE;
        return r;
    endfunction

    function automatic st_t header_line_end(st_t s, logic [5:0] limit);
        st_t r;
        logic [1:0] k;
        logic too_long, good;
        r = s;
        if (r.col == 9'd0)
            return decide(r);
        if (r.lcnt == 6'd0)
            r.status = ((r.smode == SM_TOKEN || r.smode == SM_DONE) && !r.neg)
                       ? r.acc[9:0] : 10'd0;
        if (r.nm[4])
        begin
            k = active_key(r.nm);
            too_long = (r.span >= hmf_pkg::VALUE_MAX);
            if (k == hmf_pkg::KEY_CL)
                good = !too_long && r.vmode == VM_DIGITS && !(r.neg && r.acc != 32'd0);
            else if (k == hmf_pkg::KEY_TE)
                good = !too_long && r.span >= 9'd7 && !r.mism;
            else
                good = !too_long;
            r.found[k] = 1'b1;
            if (good)
            begin
                r.verdict[k] = 1'b1;
                if (k == hmf_pkg::KEY_CL)
                    r.declared = r.neg ? 31'd0 : r.acc[30:0];
            end
        end
        r = count_line(r, limit);
        return clear_line(r);
    endfunction

    // header and trailer lines
    function automatic st_t line_step(st_t s, hmf_pkg::item_t it, logic hdr, logic [5:0] limit);
        st_t r;
        r = s;
        if (it.b == hmf_pkg::CH_LF)
        begin
            r.crp = 1'b0;
            if (hdr)
                r = header_line_end(r, limit);
            else if (r.col == 9'd0)
                r.phase = hmf_pkg::PH_DONE;
            else
                r = clear_line(count_line(r, limit));
        end
        else
        begin
            if (r.crp)
            begin
                r.crp = 1'b0;
                if (hdr)
                    r = header_content(r, hmf_pkg::classify(1'b0, hmf_pkg::CH_CR));
                else if (r.col < hmf_pkg::COL_MAX)
                    r.col = r.col + 9'd1;
            end
            if (it.b == hmf_pkg::CH_CR)
                r.crp = 1'b1;
            else if (hdr)
                r = header_content(r, it);
            else if (r.col < hmf_pkg::COL_MAX)
                r.col = r.col + 9'd1;
        end
        return r;
    endfunction

    function automatic st_t size_end(st_t s, logic ext);
        st_t r;
        logic [31:0] sum;
        r = s;
        sum = {1'b0, r.declared} + r.acc;
        if (r.span == 9'd0 || (r.neg && r.acc != 32'd0))
            r.phase = hmf_pkg::PH_ERROR;
        else if (r.acc == 32'd0)
        begin
            r.remaining = '0;
            r.phase = ext ? hmf_pkg::PH_EXT : hmf_pkg::PH_TRAILER;
            r = clear_line(r);
        end
        else if (sum[31])
            r.phase = hmf_pkg::PH_ERROR;
        else
        begin
            r.declared = sum[30:0];
            r.remaining = r.acc[30:0];
            r.phase = ext ? hmf_pkg::PH_EXT : hmf_pkg::PH_DATA;
            r.crp = 1'b0;
        end
        return r;
    endfunction

    // hex chunk size line
    function automatic st_t size_byte(st_t s, hmf_pkg::item_t it);
        st_t r;
        r = s;
        if (it.b == hmf_pkg::CH_LF)
            r = size_end(r, 1'b0);
        else if (r.crp)
            r.phase = hmf_pkg::PH_ERROR;
        else if (it.b == hmf_pkg::CH_CR)
            r.crp = 1'b1;
        else if (it.b == ";")
            r = size_end(r, 1'b1);
        else if (it.b == "-" && r.col == 9'd0)
            r.neg = 1'b1;
        else if (!it.is_hex || r.acc > hmf_pkg::HEX_ACC_MAX)
            r.phase = hmf_pkg::PH_ERROR;
        else
        begin
            r.acc = {r.acc[27:0], it.nib};
            r.span = 9'd1;
        end
        if (it.b != hmf_pkg::CH_LF && !s.crp && it.b != hmf_pkg::CH_CR && it.b != ";"
            && r.phase != hmf_pkg::PH_ERROR && r.col < hmf_pkg::COL_MAX)
            r.col = r.col + 9'd1;
        return r;
    endfunction

    assign pop = head.valid && (!valid_reg || !result_stall);

    // one message step per popped transaction
    always_comb
    begin
        hmf_pkg::item_t it;
        it = head.item;
        st_next = st_reg;
        payload_next = 1'b0;
        if (it.op)
            st_next = clear_all(st_reg);
        else
        begin
            unique case (st_reg.phase)
                hmf_pkg::PH_HEADER:  st_next = line_step(st_reg, it, 1'b1, line_limit);
                hmf_pkg::PH_TRAILER: st_next = line_step(st_reg, it, 1'b0, line_limit);
                hmf_pkg::PH_SIZE:    st_next = size_byte(st_reg, it);
                hmf_pkg::PH_DATA:
                begin
                    if (st_reg.remaining != 31'd0)
                    begin
                        st_next.remaining = st_reg.remaining - 31'd1;
                        payload_next = 1'b1;
                    end
                    else if (it.b == hmf_pkg::CH_LF)
                    begin
                        st_next.phase = hmf_pkg::PH_SIZE;
                        st_next = clear_line(st_next);
                    end
                    else if (!st_reg.crp && it.b == hmf_pkg::CH_CR)
                        st_next.crp = 1'b1;
                    else
                        st_next.phase = hmf_pkg::PH_ERROR;
                end
                hmf_pkg::PH_EXT:
                begin
                    if (it.b == hmf_pkg::CH_LF)
                    begin
                        st_next.phase = (st_reg.remaining != 31'd0)
                                        ? hmf_pkg::PH_DATA : hmf_pkg::PH_TRAILER;
                        st_next = clear_line(st_next);
                    end
                end
                hmf_pkg::PH_LENGTH:
                begin
                    payload_next = 1'b1;
                    if (st_reg.remaining != 31'd0)
                        st_next.remaining = st_reg.remaining - 31'd1;
                    if (st_next.remaining == 31'd0)
                        st_next.phase = hmf_pkg::PH_DONE;
                end
                default: st_next = st_reg;
            endcase
        end
    end

    // parse state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
            payload_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            st_reg <= st_next;
            payload_reg <= payload_next;
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    assign result_valid = valid_reg;
    assign parse_state = st_reg.phase;
    assign payload_byte = payload_reg;
    assign status_code = st_reg.status;
    assign http_version = st_reg.version;
    assign body_length = st_reg.declared;

endmodule

FILE: rtl/http_message_framer_core.sv
// HTTP/1.x message framer: takes one byte per cycle while item_stall is low and
// returns one result per byte, sustaining one byte per clock unless results stall.
// Each byte is registered into the classify queue, then parsed from the queue head
// into the state register, which holds the whole message state and is updated once
// per byte. A stalled result holds the parser, and the two-entry queue then fills
// and stalls the input. The user must write header_line_limit only while no
// transaction is in flight; the block itself does not enforce it.
module http_message_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        burst_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [3:0]  parse_state,
    output logic        payload_byte,
    output logic [9:0]  status_code,
    output logic [1:0]  http_version,
    output logic [30:0] body_length,
    input  logic        config_write,
    input  logic [5:0]  config_data
);

    logic           queue_full;
    logic           push;
    hmf_pkg::item_t push_item;
    logic           pop;
    hmf_pkg::head_t head;
    logic [5:0]     limit_reg;

    // header line limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= hmf_pkg::LIMIT_RESET;
        else if (config_write)
            limit_reg <= config_data;
    end

    hmf_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .operation  (operation),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    hmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .head      (head)
    );

    hmf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .line_limit   (limit_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .parse_state  (parse_state),
        .payload_byte (payload_byte),
        .status_code  (status_code),
        .http_version (http_version),
        .body_length  (body_length)
    );

endmodule

FILE: sim/tb_http_message_framer_core.sv
`timescale 1ns / 100ps

module tb_http_message_framer_core;

    localparam int unsigned LEN_LIMIT  = 32'h7FFF_FFFF;
    localparam int          IDLE_LIMIT = 4000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          TARGET_ITEMS = 1950;

    typedef struct packed {
        bit [3:0]  state;
        bit        payload;
        bit [9:0]  code;
        bit [1:0]  version;
        bit [30:0] length;
    } framer_result_t;

    typedef struct {
        bit       op;
        bit [7:0] value;
        bit       last;
    } byte_item_t;

    // framing predictor and expected result store
    class framer_scoreboard;
        int unsigned line_limit;
        int unsigned phase;
        int unsigned col;
        int unsigned lines;
        int unsigned name_flags;
        int unsigned found;
        int unsigned verdict;
        int unsigned acc;
        int unsigned status;
        int unsigned version;
        int unsigned declared;
        int unsigned remain;
        int unsigned span;
        int unsigned vmode;
        int unsigned smode;
        bit          neg;
        bit          text_bad;
        bit          cr_seen;
        string       key_name[4];
        string       chunk_word;
        framer_result_t expected_q[$];
        int          mismatches;

        function new();
            key_name = '{"content-length", "transfer-encoding",
                         "sec-websocket-key", "sec-websocket-accept"};
            chunk_word = "chunked";
            line_limit = 32;
            mismatches = 0;
            clear_all();
        endfunction

        function int unsigned lower(int unsigned c);
            return (c >= "A" && c <= "Z") ? c + 32 : c;
        endfunction

        function bit is_space(int unsigned c);
            return c == " " || (c >= 9 && c <= 13);
        endfunction

        function bit is_digit(int unsigned c);
            return c >= "0" && c <= "9";
        endfunction

        function int hex_value(int unsigned c);
            if (is_digit(c))
                return c - "0";
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            return -1;
        endfunction

        function void clear_line();
            col = 0;
            name_flags = (~found) & 4'hF;
            acc = 0;
            span = 0;
            vmode = 0;
            neg = 0;
            text_bad = 0;
            smode = 0;
            cr_seen = 0;
        endfunction

        function void clear_all();
            phase = hmf_pkg::PH_HEADER;
            lines = 0;
            found = 0;
            verdict = 0;
            status = 0;
            version = 0;
            declared = 0;
            remain = 0;
            clear_line();
        endfunction

        function int unsigned active_key();
            for (int k = 0; k < 4; k++)
                if (name_flags & (1 << k))
                    return k;
            return 0;
        endfunction

        function void count_line();
            int unsigned lim;
            lim = line_limit < 32 ? line_limit : 32;
            if (lines < lim)
                lines++;
            else
                phase = hmf_pkg::PH_ERROR;
        endfunction

        // status line: version digits then the code token
        function void status_byte(int unsigned b, int unsigned c);
            if (smode == 0)
            begin
                if (c == 5 && b != "1")
                    smode = 4;
                else if (c == 6 && b != ".")
                    smode = 4;
                else if (c == 7)
                begin
                    if (b == "1")
                        version = 2;
                    else if (b == "0")
                        version = 1;
                    else
                        smode = 4;
                end
                else if (c == 8)
                    smode = 1;
                return;
            end
            if (smode == 1)
            begin
                if (b == " ")
                    return;
                smode = 2;
            end
            if (smode != 2)
                return;
            if (b == " ")
            begin
                smode = 3;
                return;
            end
            span++;
            if (span >= 256)
                smode = 4;
            else if (span == 1 && b == "-")
                neg = 1;
            else if (is_digit(b))
            begin
                acc = acc * 10 + (b - "0");
                if (acc > 999)
                    smode = 4;
            end
            else
                smode = 4;
        endfunction

        // header value bytes
        function void value_byte(int unsigned k, int unsigned b);
            int unsigned d;
            if (vmode == 0)
            begin
                if (b == " " || b == ":")
                    return;
                vmode = 1;
            end
            if (span < 256)
                span++;
            if (k == hmf_pkg::KEY_TE && span <= 7 && b != chunk_word[span - 1])
                text_bad = 1;
            if (k != hmf_pkg::KEY_CL || vmode == 4)
                return;
            if (vmode == 1 && !is_digit(b))
            begin
                if (is_space(b))
                    return;
                if (b == "+" || b == "-")
                begin
                    neg = (b == "-");
                    vmode = 2;
                end
                else
                    vmode = 4;
                return;
            end
            if (!is_digit(b))
            begin
                vmode = 4;
                return;
            end
            vmode = 3;
            d = b - "0";
            if (acc > (LEN_LIMIT - d) / 10)
                vmode = 4;
            else
                acc = acc * 10 + d;
        endfunction

        function void header_content(int unsigned b);
            int unsigned c;
            c = col;
            if (lines == 0)
                status_byte(b, c);
            if (name_flags & 5'h10)
                value_byte(active_key(), b);
            else
            begin
                for (int k = 0; k < 4; k++)
                    if ((name_flags & (1 << k)) && c < key_name[k].len() &&
                        lower(b) != key_name[k][c])
                        name_flags &= ~(1 << k);
                for (int k = 0; k < 4; k++)
                    if ((name_flags & (1 << k)) && c + 1 == key_name[k].len())
                        name_flags |= 5'h10;
            end
            if (col < 511)
                col++;
        endfunction

        // framing choice at the empty line
        function void decide();
            if (verdict & 1)
            begin
                remain = declared;
                phase = declared == 0 ? hmf_pkg::PH_DONE : hmf_pkg::PH_LENGTH;
            end
            else if (verdict & 2)
            begin
                declared = 0;
                phase = hmf_pkg::PH_SIZE;
                clear_line();
            end
            else if (verdict & 4'hC)
                phase = hmf_pkg::PH_WEBSOCKET;
            else
                phase = status == 200 ? hmf_pkg::PH_ERROR : hmf_pkg::PH_DONE;
        endfunction

        function void header_line_end();
            int unsigned k;
            bit good;
            bit too_long;
            if (col == 0)
            begin
                decide();
                return;
            end
            if (lines == 0)
                status = ((smode == 2 || smode == 3) && !neg) ? acc : 0;
            if (name_flags & 5'h10)
            begin
                k = active_key();
                too_long = span >= 256;
                if (k == hmf_pkg::KEY_CL)
                    good = !too_long && vmode == 3 && !(neg && acc != 0);
                else if (k == hmf_pkg::KEY_TE)
                    good = !too_long && span >= 7 && !text_bad;
                else
                    good = !too_long;
                found |= 1 << k;
                if (good)
                begin
                    verdict |= 1 << k;
                    if (k == hmf_pkg::KEY_CL)
                        declared = neg ? 0 : acc;
                end
            end
            count_line();
            clear_line();
        endfunction

        function void line_step(int unsigned b, bit header);
            if (b == hmf_pkg::CH_LF)
            begin
                cr_seen = 0;
                if (header)
                    header_line_end();
                else if (col == 0)
                    phase = hmf_pkg::PH_DONE;
                else
                begin
                    count_line();
                    clear_line();
                end
                return;
            end
            if (cr_seen)
            begin
                cr_seen = 0;
                if (header)
                    header_content(hmf_pkg::CH_CR);
                else if (col < 511)
                    col++;
            end
            if (b == hmf_pkg::CH_CR)
                cr_seen = 1;
            else if (header)
                header_content(b);
            else if (col < 511)
                col++;
        endfunction

        function void size_end(bit ext);
            int unsigned v;
            v = acc;
            if (span == 0 || (neg && v != 0))
            begin
                phase = hmf_pkg::PH_ERROR;
                return;
            end
            if (v == 0)
            begin
                remain = 0;
                phase = ext ? hmf_pkg::PH_EXT : hmf_pkg::PH_TRAILER;
                clear_line();
                return;
            end
            if (v > LEN_LIMIT - declared)
            begin
                phase = hmf_pkg::PH_ERROR;
                return;
            end
            declared += v;
            remain = v;
            phase = ext ? hmf_pkg::PH_EXT : hmf_pkg::PH_DATA;
            cr_seen = 0;
        endfunction

        function void size_byte(int unsigned b);
            int d;
            if (b == hmf_pkg::CH_LF)
            begin
                size_end(0);
                return;
            end
            if (cr_seen)
            begin
                phase = hmf_pkg::PH_ERROR;
                return;
            end
            if (b == hmf_pkg::CH_CR)
            begin
                cr_seen = 1;
                return;
            end
            if (b == ";")
            begin
                size_end(1);
                return;
            end
            d = hex_value(b);
            if (b == "-" && col == 0)
                neg = 1;
            else if (d < 0 || acc > (LEN_LIMIT - d) / 16)
            begin
                phase = hmf_pkg::PH_ERROR;
                return;
            end
            else
            begin
                acc = acc * 16 + d;
                span = 1;
            end
            if (col < 511)
                col++;
        endfunction

        function bit data_step(int unsigned b);
            if (remain > 0)
            begin
                remain--;
                return 1;
            end
            if (b == hmf_pkg::CH_LF)
            begin
                phase = hmf_pkg::PH_SIZE;
                clear_line();
            end
            else if (!cr_seen && b == hmf_pkg::CH_CR)
                cr_seen = 1;
            else
                phase = hmf_pkg::PH_ERROR;
            return 0;
        endfunction

        // accepted input transaction: advance state, queue its result
        function void note_byte(bit op, bit [7:0] bv);
            int unsigned b;
            bit pay;
            framer_result_t r;
            b = bv;
            pay = 0;
            if (op)
                clear_all();
            else
                case (phase)
                    hmf_pkg::PH_HEADER:  line_step(b, 1);
                    hmf_pkg::PH_TRAILER: line_step(b, 0);
                    hmf_pkg::PH_SIZE:    size_byte(b);
                    hmf_pkg::PH_DATA:    pay = data_step(b);
                    hmf_pkg::PH_EXT:
                        if (b == hmf_pkg::CH_LF)
                        begin
                            phase = remain > 0 ? hmf_pkg::PH_DATA : hmf_pkg::PH_TRAILER;
                            clear_line();
                        end
                    hmf_pkg::PH_LENGTH:
                    begin
                        pay = 1;
                        if (remain > 0)
                            remain--;
                        if (remain == 0)
                            phase = hmf_pkg::PH_DONE;
                    end
                    default: ;
                endcase
            r.state = phase[3:0];
            r.payload = pay;
            r.code = status[9:0];
            r.version = version[1:0];
            r.length = declared[30:0];
            expected_q.push_back(r);
        endfunction

        // accepted result transaction against the oldest expectation
        function void check_result(framer_result_t got);
            framer_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: state %0d", got.state);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got != exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp st %0d pay %0d code %0d ver %0d len %0d",
                              " / got st %0d pay %0d code %0d ver %0d len %0d"},
                             exp_r.state, exp_r.payload, exp_r.code, exp_r.version,
                             exp_r.length, got.state, got.payload, got.code,
                             got.version, got.length);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic        operation;
    logic [7:0]  data_byte;
    logic        burst_end;
    logic        result_valid;
    logic        result_stall;
    logic [3:0]  parse_state;
    logic        payload_byte;
    logic [9:0]  status_code;
    logic [1:0]  http_version;
    logic [30:0] body_length;
    logic        config_write;
    logic [5:0]  config_data;

    framer_scoreboard sb;
    byte_item_t byte_q[$];
    int  items_sent;
    int  idle_cycles;
    bit  long_hold;
    bit  no_gaps;

    http_message_framer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .data_byte    (data_byte),
        .burst_end    (burst_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .parse_state  (parse_state),
        .payload_byte (payload_byte),
        .status_code  (status_code),
        .http_version (http_version),
        .body_length  (body_length),
        .config_write (config_write),
        .config_data  (config_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // result monitor
    always @(posedge clk)
    begin
        framer_result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.state = parse_state;
            got.payload = payload_byte;
            got.code = status_code;
            got.version = http_version;
            got.length = body_length;
            sb.check_result(got);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("http_message_framer_core verification failed");
                $finish;
            end
        end
    end

    // result receiver with random and long stalls
    initial
    begin
        int n;
        result_stall = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            n = no_gaps ? 0 : $urandom_range(0, 5);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // one input transaction, entered and left at a falling edge
    task automatic send_byte(byte_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        operation <= it.op;
        data_byte <= it.value;
        burst_end <= it.last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_byte(it.op, it.value);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic flush_bytes();
        while (byte_q.size() > 0)
            send_byte(byte_q.pop_front());
    endtask

    task automatic push_byte(bit op, bit [7:0] v);
        byte_item_t it;
        it.op = op;
        it.value = v;
        it.last = 1'($urandom_range(0, 1));
        byte_q.push_back(it);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(0, s[i]);
    endtask

    task automatic push_eol();
        if ($urandom_range(0, 3) == 0)
            push_text("\n");
        else
            push_text("\r\n");
    endtask

    function automatic string mix_case(string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if (((r[i] >= "a" && r[i] <= "z") || (r[i] >= "A" && r[i] <= "Z")) &&
                $urandom_range(0, 1))
                r[i] = r[i] ^ 8'h20;
        return r;
    endfunction

    task automatic drain_results();
        item_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(bit [5:0] v);
        drain_results();
        config_write <= 1'b1;
        config_data <= v;
        @(negedge clk);
        config_write <= 1'b0;
        sb.line_limit = v;
    endtask

    // one random message: status line, headers, framing, body, or a run of random bytes
    task automatic build_message();
        int nh;
        int clen;
        bit chunked;
        string s;
        push_byte(1, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 30)) push_byte(0, 8'($urandom_range(0, 255)));
            return;
        end
        // status line
        case ($urandom_range(0, 6))
            0, 1, 2: s = "HTTP/1.1 ";
            3:       s = "HTTP/1.0 ";
            4:       s = "HTTP/2.0 ";
            5:       s = "";
            default: s = "HTTP/1.x  ";
        endcase
        if (s.len() > 0)
        begin
            case ($urandom_range(0, 7))
                0, 1:    s = {s, "200"};
                2:       s = {s, "404"};
                3:       s = {s, "101"};
                4:       s = {s, $sformatf("%0d", $urandom_range(0, 1200))};
                5:       s = {s, "-7"};
                6:       s = {s, "12a"};
                default: s = {s, ""};
            endcase
            if ($urandom_range(0, 1))
                s = {s, " OK"};
        end
        push_text(s);
        push_eol();
        // header lines
        nh = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 4);
        clen = -1;
        chunked = 0;
        for (int h = 0; h < nh; h++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    s = {mix_case("Content-Length"), ": "};
                    case ($urandom_range(0, 9))
                        0:       s = {s, "0"};
                        1:       s = {s, "+3"};
                        2:       s = {s, "-0"};
                        3:       s = {s, "-4"};
                        4:       s = {s, "99999999999"};
                        5:       s = {s, "2147483648"};
                        6:       s = {s, " 7 x"};
                        default:
                        begin
                            if (clen < 0)
                                clen = $urandom_range(1, 12);
                            s = {s, $sformatf("%0d", clen)};
                        end
                    endcase
                end
                1:
                begin
                    case ($urandom_range(0, 3))
                        0:       s = "gzip";
                        1:       s = "chunkedx";
                        default: s = "chunked";
                    endcase
                    s = {mix_case("Transfer-Encoding"), ":", s};
                    chunked = 1;
                end
                2:       s = {mix_case("Sec-WebSocket-Key"), ": dGhlIHNhbXBsZQ=="};
                3:       s = {mix_case("Sec-WebSocket-Accept"), ": s3pPLMBiTxaQ9k"};
                4:       s = $sformatf("X-Tag%0d: v", $urandom_range(0, 99));
                default:
                begin
                    s = "";
                    repeat ($urandom_range(1, 8))
                        s = {s, string'(byte'($urandom_range(0, 255)))};
                end
            endcase
            push_text(s);
            push_eol();
        end
        push_eol();
        // body
        if (clen > 0)
            repeat (clen) push_byte(0, 8'($urandom_range(0, 255)));
        else if (chunked)
        begin
            repeat ($urandom_range(1, 3))
            begin
                nh = $urandom_range(1, 12);
                push_text($urandom_range(0, 1) ? $sformatf("%0x", nh) : $sformatf("%0X", nh));
                if ($urandom_range(0, 3) == 0)
                    push_text(";ext=1");
                push_eol();
                repeat (nh) push_byte(0, 8'($urandom_range(0, 255)));
                push_eol();
            end
            push_text($urandom_range(0, 3) == 0 ? "0;x" : "0");
            push_eol();
            if ($urandom_range(0, 1))
            begin
                push_text("X-Trailer: 1");
                push_eol();
            end
            push_eol();
        end
        // stray bytes after the message or inside a broken one
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) push_byte(0, 8'($urandom_range(0, 255)));
    endtask

    // main sequence
    initial
    begin
        bit [5:0] limits[6];
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        operation = 1'b0;
        data_byte = 8'h00;
        burst_end = 1'b0;
        config_write = 1'b0;
        config_data = 6'd0;
        items_sent = 0;
        idle_cycles = 0;
        long_hold = 1'b0;
        no_gaps = 1'b0;
        limits = '{6'd32, 6'd1, 6'd3, 6'd31, 6'd32, 6'd0};
        limits[5] = 6'($urandom_range(2, 30));
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: status 200 with no framing, then bytes in the finished phases
        write_limit(6'd32);
        push_byte(1, 8'hFF);
        push_text("HTTP/1.1 200 OK\r\n\r\n");
        push_byte(0, 8'hFF);
        push_byte(1, 8'h00);
        push_text("\n");
        push_byte(0, 8'h00);
        flush_bytes();

        for (int p = 0; p < 6; p++)
        begin
            write_limit(limits[p]);
            no_gaps = (p == 4);
            if (p == 2)
                long_hold = 1'b1;
            while (items_sent < (p + 1) * TARGET_ITEMS / 6)
            begin
                build_message();
                flush_bytes();
            end
        end

        drain_results();
        repeat (10) @(negedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("http_message_framer_core verification clean");
        else
            $display("http_message_framer_core verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/hmf_pkg.sv
rtl/hmf_front.sv
rtl/hmf_queue.sv
rtl/hmf_back.sv
rtl/http_message_framer_core.sv
sim/tb_http_message_framer_core.sv
